FILE: hdl/wdps_pkg.sv
// Shared types, constants and helper functions of the wall distance PID steering block.
// No dependencies; every hdl file imports this package.
package wdps_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_GAIN_P = 3'd0;
   localparam logic [2:0] CSR_GAIN_I = 3'd1;
   localparam logic [2:0] CSR_GAIN_D = 3'd2;
   localparam logic [2:0] CSR_TARGET = 3'd3;
   localparam logic [2:0] CSR_PERIOD = 3'd4;
   localparam logic [2:0] CSR_RATE   = 3'd5;
   localparam logic [2:0] CSR_COS    = 3'd6;
   localparam logic [2:0] CSR_SIN    = 3'd7;

   // Fixed-point constants
   localparam int ZW            = 28;          // CORDIC angle width, Q.24
   localparam int HALF_PI_Q13   = 12868;
   localparam int ROT_GAIN_Q30  = 652032874;
   localparam int STEER_10DEG   = 1429;
   localparam int STEER_20DEG   = 2859;
   localparam int MUL_AW        = 32;
   localparam int MUL_BW        = 24;
   localparam int MUL_PW        = MUL_AW + MUL_BW;

   typedef enum logic [4:0] {
      S_IDLE, S_M_NUM, S_M_DEN, S_VINIT, S_VEC, S_ALPHA, S_RINIT, S_ROT, S_CS,
      S_M_BC, S_M_SP, S_M_SPS, S_DIST, S_RND, S_ERR, S_M_GP, S_M_EP, S_INT,
      S_M_GI_LO, S_M_GI_HI, S_M_RD, S_GI_ADD, S_M_GD_LO, S_M_GD_HI, S_GD_ACC,
      S_GD_ADD, S_STEER, S_DONE
   } st_type;

   typedef struct packed {
      logic load;
      logic step;
      logic vec;
   } cordic_ctl_type;

   // atan(2^-i) in Q.24
   function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] idx);
      logic signed [ZW-1:0] v;
      case (idx)
         5'd0:  v = 28'sd13176795;
         5'd1:  v = 28'sd7778716;
         5'd2:  v = 28'sd4110060;
         5'd3:  v = 28'sd2086331;
         5'd4:  v = 28'sd1047214;
         5'd5:  v = 28'sd524117;
         5'd6:  v = 28'sd262123;
         5'd7:  v = 28'sd131069;
         5'd8:  v = 28'sd65536;
         5'd9:  v = 28'sd32768;
         5'd10: v = 28'sd16384;
         5'd11: v = 28'sd8192;
         5'd12: v = 28'sd4096;
         5'd13: v = 28'sd2048;
         5'd14: v = 28'sd1024;
         5'd15: v = 28'sd512;
         5'd16: v = 28'sd256;
         5'd17: v = 28'sd128;
         5'd18: v = 28'sd64;
         5'd19: v = 28'sd32;
         5'd20: v = 28'sd16;
         5'd21: v = 28'sd8;
         5'd22: v = 28'sd4;
         5'd23: v = 28'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Limit a product magnitude to 2^46 and apply its sign
   function automatic logic signed [49:0] term_cap(input logic [79:0] mag, input logic neg);
      logic [49:0] q;
      q = (mag > 80'h4000_0000_0000) ? 50'h4000_0000_0000 : 50'(mag);
      return neg ? -$signed(q) : $signed(q);
   endfunction

endpackage

FILE: hdl/wdps_mul.sv
// Shared unsigned 32 x 24 multiplier with a registered product.
// Depends on wdps_pkg.
module wdps_mul
   import wdps_pkg::*;
(
   input  logic              clock,
   input  logic              capture,
   input  logic [MUL_AW-1:0] op_a,
   input  logic [MUL_BW-1:0] op_b,
   output logic [MUL_PW-1:0] product
);

   logic [MUL_PW-1:0] prod_ff;

   // Capture the product when the sequencer issues a multiply
   always_ff @(posedge clock) begin
      if (capture) begin
         prod_ff <= MUL_PW'(op_a) * MUL_PW'(op_b);
      end
   end

   assign product = prod_ff;

endmodule

FILE: hdl/wdps_cordic.sv
// Shared CORDIC unit: one micro-rotation per cycle while stepped, vectoring or rotating mode.
// Depends on wdps_pkg.
module wdps_cordic
   import wdps_pkg::*;
#(
   parameter int CW    = 36,
   parameter int STEPS = 16
)
(
   input  logic                 clock,
   input  cordic_ctl_type       ctl,
   input  logic signed [CW-1:0] x_load,
   input  logic signed [CW-1:0] y_load,
   input  logic signed [ZW-1:0] z_load,
   output logic signed [CW-1:0] x_out,
   output logic signed [CW-1:0] y_out,
   output logic signed [ZW-1:0] z_out,
   output logic                 last
);

   localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic signed [CW-1:0] x_ff, y_ff, x_in, y_in, xs, ys;
   logic signed [ZW-1:0] z_ff, z_in, at;
   logic [IW-1:0]        i_ff, i_in;
   logic                 cw;

   // One micro-rotation; clockwise when y is non-negative (vectoring) or z negative
   always_comb begin
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      at = atan_q24(5'(i_ff));
      cw = ctl.vec ? ~y_ff[CW-1] : z_ff[ZW-1];
      if (cw) begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + at;
      end else begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - at;
      end
      i_in = i_ff + IW'(1);
   end

   // Load the start vector or advance one iteration
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         x_ff <= x_load;
         y_ff <= y_load;
         z_ff <= z_load;
         i_ff <= '0;
      end else if (ctl.step) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         i_ff <= i_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
   assign last  = (i_ff == IW'(STEPS - 1));

endmodule

FILE: hdl/wall_distance_pid_steering.sv
// Wall distance PID steering: sequencer over one shared CORDIC unit and one multiplier.
// Each word runs a vectoring CORDIC pass, a rotating CORDIC pass and the multiply sequence;
// a zero range_ahead*beam_sin skips the vectoring pass, a disabled word skips the PID
// sequence. One word in flight at a time: a new word is taken only after the response
// is accepted, so any response stall holds the next word back.
// Reset (synchronous, active high): idle, registers at their defaults, PID state cleared.
module wall_distance_pid_steering
   import wdps_pkg::*;
#(
   parameter int RANGE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [RANGE_BITS-1:0] req_range_ahead,
   input  logic [RANGE_BITS-1:0] req_range_side,
   input  logic                  req_enable,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_drive_valid,
   output logic [15:0]           rsp_steer_cmd,
   output logic [10:0]           rsp_speed_cmd,
   output logic [17:0]           rsp_error_out,
   output logic [16:0]           rsp_measured_distance,
   input  logic                  csr_write_en,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_data
);

   localparam int CW = (RANGE_BITS + 20 > 34) ? RANGE_BITS + 20 : 34;
   localparam int DW = RANGE_BITS + 34;

   st_type state_ff, state_in;

   // Configuration registers
   logic [31:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [15:0] target_ff, period_ff, rate_ff;
   logic [14:0] cos_ff, sin_ff;

   // Controller state
   logic signed [47:0] integ_ff;
   logic signed [17:0] last_err_ff;
   logic [10:0]        speed_ff;

   // Working registers
   logic [RANGE_BITS-1:0] a_ff, b_ff;
   logic                  en_ff;
   logic signed [CW-1:0]  num_ff;
   logic signed [15:0]    alpha_ff, cv_ff, sv_ff, steer_ff;
   logic signed [DW-1:0]  dacc_ff;
   logic signed [16:0]    dist_ff;
   logic signed [17:0]    err_ff;
   logic signed [49:0]    sum_ff;
   logic [79:0]           wacc_ff;
   logic [34:0]           dmag_ff;

   // Shared unit connections
   cordic_ctl_type       cctl;
   logic signed [CW-1:0] cx_load, cy_load, cx, cy;
   logic signed [ZW-1:0] cz_load, cz;
   logic                 clast;
   logic                 mcap;
   logic [MUL_AW-1:0]    ma;
   logic [MUL_BW-1:0]    mb;
   logic [MUL_PW-1:0]    mp;

   // Derived values
   logic [14:0]          cv_mag, sv_mag;
   logic [31:0]          gp_mag, gi_mag, gd_mag;
   logic [17:0]          err_mag;
   logic [47:0]          int_mag;
   logic signed [18:0]   diff;
   logic [18:0]          diff_mag;
   logic signed [ZW-1:0] zr, zs;
   logic signed [CW-1:0] xr, xs, yr, ys;
   logic signed [DW-1:0] dr, ds, sps;
   logic signed [18:0]   e19;
   logic signed [49:0]   isum, ep, ns, ss;
   logic signed [15:0]   alpha_cand, cv_cand, sv_cand, steer_cand;
   logic signed [16:0]   dist_cand, smag;
   logic signed [17:0]   err_cand;
   logic signed [47:0]   integ_cand;
   logic [10:0]          speed_cand;

   wdps_cordic #(.CW(CW), .STEPS(CORDIC_STEPS)) u_cordic (
      .clock  (clock),
      .ctl    (cctl),
      .x_load (cx_load),
      .y_load (cy_load),
      .z_load (cz_load),
      .x_out  (cx),
      .y_out  (cy),
      .z_out  (cz),
      .last   (clast)
   );

   wdps_mul u_mul (
      .clock   (clock),
      .capture (mcap),
      .op_a    (ma),
      .op_b    (mb),
      .product (mp)
   );

   // Magnitudes of signed operands
   always_comb begin
      cv_mag   = cv_ff[15] ? 15'(-cv_ff) : 15'(cv_ff);
      sv_mag   = sv_ff[15] ? 15'(-sv_ff) : 15'(sv_ff);
      gp_mag   = gain_p_ff[31] ? (~gain_p_ff + 32'd1) : gain_p_ff;
      gi_mag   = gain_i_ff[31] ? (~gain_i_ff + 32'd1) : gain_i_ff;
      gd_mag   = gain_d_ff[31] ? (~gain_d_ff + 32'd1) : gain_d_ff;
      err_mag  = err_ff[17] ? 18'(-err_ff) : 18'(err_ff);
      int_mag  = integ_ff[47] ? 48'(-integ_ff) : 48'(integ_ff);
      diff     = 19'(err_ff) - 19'(last_err_ff);
      diff_mag = diff[18] ? 19'(-diff) : 19'(diff);
   end

   // Rounding and limiting of intermediate results
   always_comb begin
      zr = cz + 28'sd1024;
      zs = zr >>> 11;
      if (zs > 28'sd12868)       alpha_cand = 16'sd12868;
      else if (zs < -28'sd12868) alpha_cand = -16'sd12868;
      else                       alpha_cand = 16'(zs);

      xr = cx + CW'(32768);
      xs = xr >>> 16;
      if (xs > CW'(16384))       cv_cand = 16'sd16384;
      else if (xs < CW'(-16384)) cv_cand = -16'sd16384;
      else                       cv_cand = 16'(xs);
      yr = cy + CW'(32768);
      ys = yr >>> 16;
      if (ys > CW'(16384))       sv_cand = 16'sd16384;
      else if (ys < CW'(-16384)) sv_cand = -16'sd16384;
      else                       sv_cand = 16'(ys);

      sps = $signed(DW'(mp[41:0]));
      dr  = dacc_ff + DW'(536870912);
      ds  = dr >>> 30;
      if (ds > DW'(65535))       dist_cand = 17'sd65535;
      else if (ds < DW'(-65536)) dist_cand = -17'sd65536;
      else                       dist_cand = 17'(ds);

      e19 = $signed({3'b000, target_ff}) - 19'(dist_ff);
      if (e19 > 19'sd131071)       err_cand = 18'sd131071;
      else if (e19 < -19'sd131072) err_cand = -18'sd131072;
      else                         err_cand = 18'(e19);

      ep   = $signed(50'(mp[33:0]));
      isum = 50'(integ_ff) + (err_ff[17] ? -ep : ep);
      if (isum > 50'sh7FFF_FFFF_FFFF)       integ_cand = 48'sh7FFF_FFFF_FFFF;
      else if (isum < -50'sh8000_0000_0000) integ_cand = -48'sh8000_0000_0000;
      else                                  integ_cand = 48'(isum);

      ns = 50'sd4 - sum_ff;
      ss = ns >>> 3;
      if (ss > 50'sd32767)       steer_cand = 16'sd32767;
      else if (ss < -50'sd32768) steer_cand = -16'sd32768;
      else                       steer_cand = 16'(ss);
      smag = steer_cand[15] ? -17'(steer_cand) : 17'(steer_cand);
      if (smag <= 17'sd1429)      speed_cand = 11'd2000;
      else if (smag <= 17'sd2859) speed_cand = 11'd1500;
      else                        speed_cand = 11'd1000;
   end

   // Next state, shared unit control and multiplier operands
   always_comb begin
      state_in  = state_ff;
      cctl      = '0;
      cx_load   = CW'(mp);
      cy_load   = num_ff;
      cz_load   = '0;
      mcap      = 1'b0;
      ma        = '0;
      mb        = '0;
      case (state_ff)
         S_IDLE:    if (req_valid) state_in = S_M_NUM;
         S_M_NUM: begin
            mcap = 1'b1; ma = 32'(cos_ff); mb = MUL_BW'(a_ff); state_in = S_M_DEN;
         end
         S_M_DEN: begin
            mcap = 1'b1; ma = 32'(sin_ff); mb = MUL_BW'(a_ff); state_in = S_VINIT;
         end
         S_VINIT: begin
            cctl.load = 1'b1;
            state_in  = (mp == '0) ? S_RINIT : S_VEC;
         end
         S_VEC: begin
            cctl.step = 1'b1; cctl.vec = 1'b1;
            if (clast) state_in = S_ALPHA;
         end
         S_ALPHA:   state_in = S_RINIT;
         S_RINIT: begin
            cctl.load = 1'b1;
            cx_load   = CW'(ROT_GAIN_Q30);
            cy_load   = '0;
            cz_load   = ZW'(alpha_ff) <<< 11;
            state_in  = S_ROT;
         end
         S_ROT: begin
            cctl.step = 1'b1;
            if (clast) state_in = S_CS;
         end
         S_CS:      state_in = S_M_BC;
         S_M_BC: begin
            mcap = 1'b1; ma = 32'(cv_mag); mb = MUL_BW'(b_ff); state_in = S_M_SP;
         end
         S_M_SP: begin
            mcap = 1'b1; ma = 32'(period_ff); mb = MUL_BW'(speed_ff); state_in = S_M_SPS;
         end
         S_M_SPS: begin
            mcap = 1'b1; ma = mp[31:0]; mb = MUL_BW'(sv_mag); state_in = S_DIST;
         end
         S_DIST:    state_in = S_RND;
         S_RND:     state_in = S_ERR;
         S_ERR:     state_in = en_ff ? S_M_GP : S_DONE;
         S_M_GP: begin
            mcap = 1'b1; ma = gp_mag; mb = MUL_BW'(err_mag); state_in = S_M_EP;
         end
         S_M_EP: begin
            mcap = 1'b1; ma = 32'(period_ff); mb = MUL_BW'(err_mag); state_in = S_INT;
         end
         S_INT:     state_in = S_M_GI_LO;
         S_M_GI_LO: begin
            mcap = 1'b1; ma = gi_mag; mb = int_mag[23:0]; state_in = S_M_GI_HI;
         end
         S_M_GI_HI: begin
            mcap = 1'b1; ma = gi_mag; mb = int_mag[47:24]; state_in = S_M_RD;
         end
         S_M_RD: begin
            mcap = 1'b1; ma = 32'(rate_ff); mb = MUL_BW'(diff_mag); state_in = S_GI_ADD;
         end
         S_GI_ADD:  state_in = S_M_GD_LO;
         S_M_GD_LO: begin
            mcap = 1'b1; ma = gd_mag; mb = dmag_ff[23:0]; state_in = S_M_GD_HI;
         end
         S_M_GD_HI: begin
            mcap = 1'b1; ma = gd_mag; mb = MUL_BW'(dmag_ff[34:24]); state_in = S_GD_ACC;
         end
         S_GD_ACC:  state_in = S_GD_ADD;
         S_GD_ADD:  state_in = S_STEER;
         S_STEER:   state_in = S_DONE;
         S_DONE:    if (rsp_ready) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // Hold the sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= '0;
         gain_i_ff <= '0;
         gain_d_ff <= '0;
         target_ff <= 16'd1000;
         period_ff <= 16'd546;
         rate_ff   <= 16'd120;
         cos_ff    <= 15'd12551;
         sin_ff    <= 15'd10531;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_GAIN_P: gain_p_ff <= csr_data;
            CSR_GAIN_I: gain_i_ff <= csr_data;
            CSR_GAIN_D: gain_d_ff <= csr_data;
            CSR_TARGET: target_ff <= csr_data[15:0];
            CSR_PERIOD: period_ff <= csr_data[15:0];
            CSR_RATE:   rate_ff   <= csr_data[15:0];
            CSR_COS:    cos_ff    <= csr_data[14:0];
            CSR_SIN:    sin_ff    <= csr_data[14:0];
            default:    ;
         endcase
      end
   end

   // Update controller state: integral, speed and last error
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         last_err_ff <= '0;
         speed_ff    <= '0;
      end else begin
         if (state_ff == S_INT)                 integ_ff    <= integ_cand;
         if (state_ff == S_STEER)               speed_ff    <= speed_cand;
         if (state_ff == S_DONE && rsp_ready)   last_err_ff <= err_ff;
      end
   end

   // Advance the datapath registers through the sequence
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            a_ff  <= req_range_ahead;
            b_ff  <= req_range_side;
            en_ff <= req_enable;
         end
         S_M_DEN:  num_ff <= $signed(CW'(mp[CW-2:0])) - $signed(CW'({b_ff, 14'd0}));
         S_VINIT: begin
            alpha_ff <= (num_ff > CW'(0)) ? 16'sd12868 : -16'sd12868;
         end
         S_ALPHA:  alpha_ff <= alpha_cand;
         S_CS: begin
            cv_ff <= cv_cand;
            sv_ff <= sv_cand;
         end
         S_M_SP: begin
            dacc_ff <= cv_ff[15] ? -($signed(DW'(mp[41:0])) <<< 16)
                                 : ($signed(DW'(mp[41:0])) <<< 16);
         end
         S_DIST:   dacc_ff <= dacc_ff + (sv_ff[15] ? -sps : sps);
         S_RND:    dist_ff <= dist_cand;
         S_ERR:    err_ff  <= err_cand;
         S_M_EP:   sum_ff  <= term_cap(80'(mp), gain_p_ff[31] ^ err_ff[17]);
         S_M_GI_HI: wacc_ff <= 80'(mp);
         S_M_RD:   wacc_ff <= wacc_ff + (80'(mp) << 24);
         S_GI_ADD: begin
            sum_ff  <= sum_ff + term_cap(wacc_ff >> 16, gain_i_ff[31] ^ integ_ff[47]);
            dmag_ff <= mp[34:0];
         end
         S_M_GD_HI: wacc_ff <= 80'(mp);
         S_GD_ACC: wacc_ff <= wacc_ff + (80'(mp) << 24);
         S_GD_ADD: sum_ff  <= sum_ff + term_cap(wacc_ff, gain_d_ff[31] ^ diff[18]);
         S_STEER:  steer_ff <= steer_cand;
         default:  ;
      endcase
   end

   // Drive the handshake and the response word
   assign req_ready             = (state_ff == S_IDLE) && !reset;
   assign rsp_valid             = (state_ff == S_DONE);
   assign rsp_drive_valid       = en_ff;
   assign rsp_steer_cmd         = en_ff ? steer_ff : 16'd0;
   assign rsp_speed_cmd         = en_ff ? speed_ff : 11'd0;
   assign rsp_error_out         = err_ff;
   assign rsp_measured_distance = dist_ff;

endmodule

FILE: verif/tb_wall_distance_pid_steering.sv
// Testbench for the wall distance PID steering block: directed and random range words,
// checked against an in-bench fixed-point predictor of the steering controller.
// Depends on wdps_pkg and the wall_distance_pid_steering RTL.
`timescale 1ns / 1ps

module tb_wall_distance_pid_steering;
   import wdps_pkg::*;

   localparam int RBITS      = 16;
   localparam int STEPS      = 16;
   localparam int LATENCY    = 2 * STEPS + 26;
   localparam int NUM_RANDOM = 1600;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [15:0] range_ahead;
      logic [15:0] range_side;
      logic        enable;
   } range_word_type;

   typedef struct packed {
      logic        drive_valid;
      logic [15:0] steer_cmd;
      logic [10:0] speed_cmd;
      logic [17:0] error_out;
      logic [16:0] measured_distance;
   } drive_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [15:0] req_range_ahead = '0;
   logic [15:0] req_range_side = '0;
   logic req_enable = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_drive_valid;
   logic [15:0] rsp_steer_cmd;
   logic [10:0] rsp_speed_cmd;
   logic [17:0] rsp_error_out;
   logic [16:0] rsp_measured_distance;
   logic csr_write_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   wall_distance_pid_steering #(.RANGE_BITS(RBITS), .CORDIC_STEPS(STEPS)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_range_ahead(req_range_ahead), .req_range_side(req_range_side),
      .req_enable(req_enable),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_drive_valid(rsp_drive_valid), .rsp_steer_cmd(rsp_steer_cmd),
      .rsp_speed_cmd(rsp_speed_cmd), .rsp_error_out(rsp_error_out),
      .rsp_measured_distance(rsp_measured_distance),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor copy of the registers and controller state
   longint pid_kp, pid_ki, pid_kd;
   longint tgt_mm, period_q16, rate_val, cos_q14, sin_q14;
   longint integ_acc, prev_err, cur_speed;

   range_word_type pending_words[$];
   drive_word_type expected_drive[$];
   int   mismatch_count = 0;
   longint cycle_count = 0;
   bit   sender_quiet = 1'b0;
   bit   sender_pause = 1'b0;
   bit   long_hold = 1'b0;
   bit   req_ready_seen = 1'b0;

   function automatic longint asr(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint limit(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Truncated-magnitude product, shifted and capped; overflow of 64 bits caps too
   function automatic longint capped_product(longint x, longint y, int sh, longint lim);
      bit neg;
      logic [127:0] ux, uy, q;
      neg = (x < 0) != (y < 0);
      ux = x < 0 ? 128'(-x) : 128'(x);
      uy = y < 0 ? 128'(-y) : 128'(y);
      q = ux * uy;
      if (q > 128'hFFFF_FFFF_FFFF_FFFF) q = 128'(lim);
      else q = q >> sh;
      if (q > 128'(lim)) q = 128'(lim);
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic longint atan_step(int i);
      return longint'(atan_q24(5'(i)));
   endfunction

   function automatic longint wall_alpha(longint num, longint den);
      longint x, y, z, nx;
      if (den == 0) return num > 0 ? HALF_PI_Q13 : -HALF_PI_Q13;
      x = den; y = num; z = 0;
      for (int i = 0; i < STEPS; i++) begin
         if (y >= 0) begin
            nx = x + asr(y, i); y = y - asr(x, i); z += atan_step(i);
         end else begin
            nx = x - asr(y, i); y = y + asr(x, i); z -= atan_step(i);
         end
         x = nx;
      end
      return limit(asr(z + 1024, 11), -HALF_PI_Q13, HALF_PI_Q13);
   endfunction

   task automatic rotate_alpha(input longint ang, output longint c, output longint s);
      longint x, y, z, nx;
      x = ROT_GAIN_Q30; y = 0; z = ang * 2048;
      for (int i = 0; i < STEPS; i++) begin
         if (z >= 0) begin
            nx = x - asr(y, i); y = y + asr(x, i); z -= atan_step(i);
         end else begin
            nx = x + asr(y, i); y = y - asr(x, i); z += atan_step(i);
         end
         x = nx;
      end
      c = limit(asr(x + 32768, 16), -16384, 16384);
      s = limit(asr(y + 32768, 16), -16384, 16384);
   endtask

   // Compute the drive word for one range word and advance the PID state
   task automatic predict_drive(input range_word_type w);
      longint a, b, num, den, alpha, cv, sv, wall_mm, err, deriv, sum, steer, mag, speed;
      drive_word_type d;
      a = w.range_ahead; b = w.range_side;
      num = a * cos_q14 - b * 16384;
      den = a * sin_q14;
      alpha = wall_alpha(num, den);
      rotate_alpha(alpha, cv, sv);
      wall_mm = b * cv * 65536 + cur_speed * period_q16 * sv;
      wall_mm = limit(asr(wall_mm + (64'sd1 << 29), 30), -65536, 65535);
      err = limit(tgt_mm - wall_mm, -131072, 131071);
      steer = 0; speed = 0;
      if (w.enable) begin
         deriv = (err - prev_err) * rate_val;
         integ_acc = limit(integ_acc + err * period_q16, -(64'sd1 << 47), (64'sd1 << 47) - 1);
         sum = capped_product(pid_kp, err, 0, 64'sd1 << 46)
             + capped_product(pid_ki, integ_acc, 16, 64'sd1 << 46)
             + capped_product(pid_kd, deriv, 0, 64'sd1 << 46);
         steer = limit(asr(-sum + 4, 3), -32768, 32767);
         mag = steer < 0 ? -steer : steer;
         if (mag <= STEER_10DEG) speed = 2000;
         else if (mag <= STEER_20DEG) speed = 1500;
         else speed = 1000;
         cur_speed = speed;
      end
      prev_err = err;
      d.drive_valid = w.enable;
      d.steer_cmd = 16'(steer);
      d.speed_cmd = 11'(speed);
      d.error_out = 18'(err);
      d.measured_distance = 17'(wall_mm);
      expected_drive.push_back(d);
   endtask

   // Write one register at the falling edge, mirror it in the predictor
   task automatic write_csr(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1; csr_index <= idx; csr_data <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_GAIN_P: pid_kp = longint'($signed(val));
         CSR_GAIN_I: pid_ki = longint'($signed(val));
         CSR_GAIN_D: pid_kd = longint'($signed(val));
         CSR_TARGET: tgt_mm = val[15:0];
         CSR_PERIOD: period_q16 = val[15:0];
         CSR_RATE:   rate_val = val[15:0];
         CSR_COS:    cos_q14 = val[14:0];
         CSR_SIN:    sin_q14 = val[14:0];
         default:    ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_valid || expected_drive.size() != 0)
         @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   function automatic range_word_type make_word(longint a, longint b, bit en);
      range_word_type w;
      w.range_ahead = 16'(a); w.range_side = 16'(b); w.enable = en;
      return w;
   endfunction

   // Mostly plausible wall geometry, sometimes anything
   function automatic range_word_type random_word();
      range_word_type w;
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         w.range_side = 16'($urandom_range(200, 4000));
         w.range_ahead = 16'($urandom_range(200, 6000));
      end else if (kind == 7) begin
         w.range_side = 16'($urandom_range(0, 3));
         w.range_ahead = 16'($urandom_range(0, 3));
      end else begin
         w.range_side = 16'($urandom);
         w.range_ahead = 16'($urandom);
      end
      w.enable = ($urandom_range(0, 5) != 0);
      return w;
   endfunction

   task automatic pick_gains();
      write_csr(CSR_GAIN_P, $urandom_range(0, 3) == 0 ? $urandom
                            : 32'($signed($urandom_range(0, 200)) - 100));
      write_csr(CSR_GAIN_I, $urandom_range(0, 3) == 0 ? $urandom
                            : 32'($signed($urandom_range(0, 40)) - 20));
      write_csr(CSR_GAIN_D, $urandom_range(0, 3) == 0 ? $urandom
                            : 32'($signed($urandom_range(0, 20)) - 10));
      write_csr(CSR_TARGET, $urandom_range(0, 4000));
      write_csr(CSR_PERIOD, $urandom_range(1, 65535));
      write_csr(CSR_RATE, $urandom_range(1, 65535));
      write_csr(CSR_COS, $urandom_range(0, 16384));
      write_csr(CSR_SIN, $urandom_range(0, 16384));
   endtask

   // Stimulus sequence
   initial begin
      pid_kp = 0; pid_ki = 0; pid_kd = 0;
      tgt_mm = 1000; period_q16 = 546; rate_val = 120;
      cos_q14 = 12551; sin_q14 = 10531;
      integ_acc = 0; prev_err = 0; cur_speed = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset defaults, field extremes, zero denominators
      pending_words.push_back(make_word(1000, 800, 1'b1));
      pending_words.push_back(make_word(0, 0, 1'b1));
      pending_words.push_back(make_word(0, 500, 1'b1));
      pending_words.push_back(make_word(65535, 65535, 1'b1));
      pending_words.push_back(make_word(65535, 0, 1'b0));
      pending_words.push_back(make_word(0, 65535, 1'b0));
      pending_words.push_back(make_word(16'h5555, 16'hAAAA, 1'b1));
      pending_words.push_back(make_word(16'hAAAA, 16'h5555, 1'b1));
      foreach (pending_words[i]) predict_drive(pending_words[i]);
      wait_drained();

      // Directed: large gains and register extremes
      write_csr(CSR_GAIN_P, 32'h7FFF_FFFF);
      write_csr(CSR_GAIN_I, 32'h8000_0000);
      write_csr(CSR_GAIN_D, 32'h7FFF_FFFF);
      write_csr(CSR_TARGET, 32'h0000_FFFF);
      write_csr(CSR_PERIOD, 32'h0000_FFFF);
      write_csr(CSR_RATE, 32'h0000_FFFF);
      write_csr(CSR_COS, 16384);
      write_csr(CSR_SIN, 0);
      for (int i = 0; i < 6; i++) begin
         pending_words.push_back(make_word(i * 13000, 65535 - i * 9000, 1'b1));
         predict_drive(pending_words[$]);
      end
      wait_drained();
      write_csr(CSR_GAIN_P, 32'h8000_0000);
      write_csr(CSR_GAIN_I, 32'h7FFF_FFFF);
      write_csr(CSR_GAIN_D, 32'h8000_0000);
      write_csr(CSR_TARGET, 0);
      write_csr(CSR_PERIOD, 1);
      write_csr(CSR_RATE, 1);
      write_csr(CSR_COS, 0);
      write_csr(CSR_SIN, 16384);
      for (int i = 0; i < 6; i++) begin
         pending_words.push_back(make_word(65535 - i * 11000, i * 7000, i != 2));
         predict_drive(pending_words[$]);
      end
      wait_drained();

      // Random phases, each under its own register setting
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 0) begin
            write_csr(CSR_GAIN_P, 32'hFFFF_FFC0);
            write_csr(CSR_GAIN_I, 32'h0000_0002);
            write_csr(CSR_GAIN_D, 32'hFFFF_FFFE);
            write_csr(CSR_TARGET, 1000);
            write_csr(CSR_PERIOD, 546);
            write_csr(CSR_RATE, 120);
            write_csr(CSR_COS, 12551);
            write_csr(CSR_SIN, 10531);
         end else pick_gains();
         if (ph == 3) long_hold = 1'b1;
         if (ph == 7) sender_quiet = 1'b1;
         for (int i = 0; i < NUM_RANDOM / 8; i++) begin
            pending_words.push_back(random_word());
            predict_drive(pending_words[$]);
            if (ph == 2 && i == 100) begin
               // Hold the sender until every outstanding drive word is back
               while (pending_words.size() != 0) @(negedge clock);
               sender_pause = 1'b1;
               while (req_valid || expected_drive.size() != 0) @(negedge clock);
               sender_pause = 1'b0;
            end
         end
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Driver: offer queued words with random gaps
   int send_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_ready_seen) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0 && !sender_pause) begin
               range_word_type w;
               w = pending_words.pop_front();
               req_valid <= 1'b1;
               req_range_ahead <= w.range_ahead;
               req_range_side <= w.range_side;
               req_enable <= w.enable;
               if (!sender_quiet && $urandom_range(0, 5) == 0)
                  send_gap <= $urandom_range(1, 19);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Record acceptance at the rising edge for the driver
   always @(posedge clock) req_ready_seen <= req_valid && req_ready;

   // Receiver stall control, including one long hold-off
   int stall_left = 0;
   int hold_count = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_hold && hold_count < 600) begin
         hold_count <= hold_count + 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!sender_quiet && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 19);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: compare each accepted drive word with the oldest prediction
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_drive.size() == 0) begin
            $error("unexpected drive word");
            mismatch_count = mismatch_count + 1;
         end else begin
            drive_word_type e;
            e = expected_drive.pop_front();
            if (rsp_drive_valid !== e.drive_valid) begin
               $error("drive_valid expected %0d actual %0d", e.drive_valid, rsp_drive_valid);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_steer_cmd !== e.steer_cmd) begin
               $error("steer_cmd expected %0d actual %0d",
                      $signed(e.steer_cmd), $signed(rsp_steer_cmd));
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_speed_cmd !== e.speed_cmd) begin
               $error("speed_cmd expected %0d actual %0d", e.speed_cmd, rsp_speed_cmd);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_error_out !== e.error_out) begin
               $error("error_out expected %0d actual %0d",
                      $signed(e.error_out), $signed(rsp_error_out));
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_measured_distance !== e.measured_distance) begin
               $error("measured_distance expected %0d actual %0d",
                      $signed(e.measured_distance), $signed(rsp_measured_distance));
               mismatch_count = mismatch_count + 1;
            end
         end
      end
   end

endmodule
